/* rtl/tpspwm_pkg.sv */
// Shared constants and types for the three-phase sine PWM block.
`default_nettype none

package tpspwm_pkg;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_INDEX_LSB  = 2;

   localparam logic [CSR_ADDR_WIDTH-CSR_INDEX_LSB-1:0] REG_SWITCHING_PERIOD = 1'b0;

   localparam logic [31:0] PERIOD_RESET = 32'd1000;
   localparam int PERIOD_FIELD_WIDTH = 16;

   localparam int RSP_USER_WIDTH = 2;
   localparam int USER_CLIPPED   = 0;
   localparam int USER_DC_FAULT  = 1;

   typedef struct packed {
      logic lo;
      logic hi;
   } sat_flags_type;

endpackage

`default_nettype wire

/* rtl/three_phase_spwm_min_max_injection.sv */
// Three-phase sine PWM off-time generator with min-max zero-sequence injection.
// Throughput: one transaction per cycle, set by a pipelined restoring divider
// that resolves one quotient bit per stage; each stage holds on a stall.
// Reset clears all stage valid bits and loads the switching period with 1000.
`default_nettype none

module three_phase_spwm_min_max_injection #(
   parameter int VOLT_WIDTH = 16,
   parameter int TIME_WIDTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   // tdata: voltage_a, voltage_b, voltage_c, dc_link_voltage
   input  wire logic [((4*VOLT_WIDTH+7)/8)*8-1:0]          req_tdata,
   input  wire logic                                       req_tvalid,
   output      logic                                       req_tready,
   // tdata: off_time_a, off_time_b, off_time_c
   output      logic [((3*TIME_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // tuser: clipped, dc_fault
   output      logic [tpspwm_pkg::RSP_USER_WIDTH-1:0]      rsp_tuser,
   output      logic                                       rsp_tvalid,
   input  wire logic                                       rsp_tready,
   input  wire logic                                       csr_psel,
   input  wire logic                                       csr_penable,
   input  wire logic                                       csr_pwrite,
   input  wire logic [tpspwm_pkg::CSR_ADDR_WIDTH-1:0]      csr_paddr,
   input  wire logic [tpspwm_pkg::CSR_DATA_WIDTH-1:0]      csr_pwdata,
   output      logic [tpspwm_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output      logic                                       csr_pready
);

   localparam int VW     = VOLT_WIDTH;
   localparam int TW     = TIME_WIDTH;
   localparam int SW     = VW + 3;
   localparam int MW     = VW + 1;
   localparam int DW     = VW + 1;
   localparam int NW     = TW + VW + 2;
   localparam int NS     = TW + 4;
   localparam int RSP_DW = ((3*TW+7)/8)*8;

   // configuration
   logic [TW-1:0] period_ff, period_in;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
      (csr_paddr[tpspwm_pkg::CSR_ADDR_WIDTH-1:tpspwm_pkg::CSR_INDEX_LSB] ==
       tpspwm_pkg::REG_SWITCHING_PERIOD);

   always_comb begin
      period_in = period_ff;
      if (csr_wr) begin
         period_in = TW'({16'h0000, csr_pwdata[tpspwm_pkg::PERIOD_FIELD_WIDTH-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= tpspwm_pkg::PERIOD_RESET[TW-1:0];
      end else begin
         period_ff <= period_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[tpspwm_pkg::CSR_ADDR_WIDTH-1:tpspwm_pkg::CSR_INDEX_LSB] ==
          tpspwm_pkg::REG_SWITCHING_PERIOD) begin
         csr_prdata = tpspwm_pkg::CSR_DATA_WIDTH'(period_ff);
      end
   end

   // stage valid chain
   logic [NS-1:0] vld_ff, vld_in, move;

   always_comb begin
      move[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS-2; k >= 0; k--) begin
         move[k] = !vld_ff[k] || move[k+1];
      end
      vld_in[0] = move[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = move[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = move[0];

   // stage 0: input register
   logic signed [VW-1:0] s0_volt_ff [3];
   logic        [VW-1:0] s0_vdc_ff;

   always_ff @(posedge clock) begin
      if (move[0]) begin
         for (int p = 0; p < 3; p++) begin
            s0_volt_ff[p] <= $signed(req_tdata[p*VW +: VW]);
         end
         s0_vdc_ff <= req_tdata[3*VW +: VW];
      end
   end

   // stage 1: injection and saturation test
   logic signed [VW-1:0]         vmax, vmin;
   logic signed [SW-1:0]         m_sum [3];
   logic signed [SW-1:0]         two_vdc;
   logic [MW-1:0]                s1_m_ff [3], s1_m_in [3];
   tpspwm_pkg::sat_flags_type    s1_sat_ff [3], s1_sat_in [3];
   logic [VW-1:0]                s1_vdc_ff;

   always_comb begin
      vmax = s0_volt_ff[0];
      vmin = s0_volt_ff[0];
      for (int p = 1; p < 3; p++) begin
         if (s0_volt_ff[p] > vmax) vmax = s0_volt_ff[p];
         if (s0_volt_ff[p] < vmin) vmin = s0_volt_ff[p];
      end
      two_vdc = SW'($signed({1'b0, s0_vdc_ff, 1'b0}));
      for (int p = 0; p < 3; p++) begin
         m_sum[p] = (SW'(s0_volt_ff[p]) <<< 1) - SW'(vmax) - SW'(vmin) +
                    SW'($signed({1'b0, s0_vdc_ff}));
         s1_sat_in[p].lo = m_sum[p][SW-1];
         s1_sat_in[p].hi = m_sum[p] > two_vdc;
         s1_m_in[p] = (s1_sat_in[p].lo || s1_sat_in[p].hi) ? '0 : m_sum[p][MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (move[1]) begin
         s1_m_ff   <= s1_m_in;
         s1_sat_ff <= s1_sat_in;
         s1_vdc_ff <= s0_vdc_ff;
      end
   end

   // stage 2: numerator period*m + vdc, divisor 2*vdc
   logic [NW-1:0]                s2_num_ff [3], s2_num_in [3];
   logic [DW-1:0]                s2_den_ff;
   tpspwm_pkg::sat_flags_type    s2_sat_ff [3];
   logic                         s2_fault_ff;

   always_comb begin
      for (int p = 0; p < 3; p++) begin
         s2_num_in[p] = NW'(period_ff) * NW'(s1_m_ff[p]) + NW'(s1_vdc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (move[2]) begin
         s2_num_ff   <= s2_num_in;
         s2_den_ff   <= {s1_vdc_ff, 1'b0};
         s2_sat_ff   <= s1_sat_ff;
         s2_fault_ff <= (s1_vdc_ff == '0);
      end
   end

   // division stages, one quotient bit each, MSB first
   logic [NW-1:0]                dv_rem_ff [TW][3];
   logic [TW-1:0]                dv_q_ff   [TW][3];
   logic [DW-1:0]                dv_den_ff [TW];
   tpspwm_pkg::sat_flags_type    dv_sat_ff [TW][3];
   logic                         dv_fault_ff [TW];

   for (genvar j = 0; j < TW; j++) begin : g_div
      localparam int B = TW - 1 - j;
      logic [NW-1:0]             src_rem [3];
      logic [TW-1:0]             src_q   [3];
      logic [DW-1:0]             src_den;
      tpspwm_pkg::sat_flags_type src_sat [3];
      logic                      src_fault;
      logic [NW-1:0]             den_sh;
      logic [NW-1:0]             rem_in  [3];
      logic [TW-1:0]             q_in    [3];

      if (j == 0) begin : g_first
         always_comb begin
            src_rem   = s2_num_ff;
            src_den   = s2_den_ff;
            src_sat   = s2_sat_ff;
            src_fault = s2_fault_ff;
            for (int p = 0; p < 3; p++) begin
               src_q[p] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            src_rem   = dv_rem_ff[j-1];
            src_q     = dv_q_ff[j-1];
            src_den   = dv_den_ff[j-1];
            src_sat   = dv_sat_ff[j-1];
            src_fault = dv_fault_ff[j-1];
         end
      end

      always_comb begin
         den_sh = NW'(src_den) << B;
         for (int p = 0; p < 3; p++) begin
            rem_in[p] = src_rem[p];
            q_in[p]   = src_q[p];
            if (src_rem[p] >= den_sh) begin
               rem_in[p] = src_rem[p] - den_sh;
               q_in[p][B] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (move[3+j]) begin
            dv_rem_ff[j]   <= rem_in;
            dv_q_ff[j]     <= q_in;
            dv_den_ff[j]   <= src_den;
            dv_sat_ff[j]   <= src_sat;
            dv_fault_ff[j] <= src_fault;
         end
      end
   end

   // output register
   logic [TW-1:0] out_time_ff [3], out_time_in [3];
   logic          out_clip_ff, out_clip_in;
   logic          out_fault_ff;

   always_comb begin
      out_clip_in = 1'b0;
      for (int p = 0; p < 3; p++) begin
         priority if (dv_fault_ff[TW-1]) begin
            out_time_in[p] = '0;
         end else if (dv_sat_ff[TW-1][p].lo) begin
            out_time_in[p] = '0;
            out_clip_in = 1'b1;
         end else if (dv_sat_ff[TW-1][p].hi) begin
            out_time_in[p] = period_ff;
            out_clip_in = 1'b1;
         end else begin
            out_time_in[p] = dv_q_ff[TW-1][p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[NS-1]) begin
         out_time_ff  <= out_time_in;
         out_clip_ff  <= out_clip_in;
         out_fault_ff <= dv_fault_ff[TW-1];
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = RSP_DW'({out_time_ff[2], out_time_ff[1], out_time_ff[0]});

   always_comb begin
      rsp_tuser = '0;
      rsp_tuser[tpspwm_pkg::USER_CLIPPED]  = out_clip_ff;
      rsp_tuser[tpspwm_pkg::USER_DC_FAULT] = out_fault_ff;
   end

endmodule

`default_nettype wire

/* rtl/tpspwm_checker.sv */
// Port-level checker for the three-phase sine PWM block, with its bind.
`default_nettype none

module tpspwm_checker #(
   parameter int VOLT_WIDTH = 16,
   parameter int TIME_WIDTH = 16
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic [((3*TIME_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   input wire logic [tpspwm_pkg::RSP_USER_WIDTH-1:0] rsp_tuser,
   input wire logic                                  rsp_tvalid,
   input wire logic                                  rsp_tready,
   input wire logic                                  csr_pready
);

   localparam int VW = VOLT_WIDTH;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result transaction changed while stalled");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[tpspwm_pkg::USER_DC_FAULT] |->
         (rsp_tdata == '0) && !rsp_tuser[tpspwm_pkg::USER_CLIPPED])
      else $error("dc fault result with nonzero times or clip");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready && (VW > 0))
      else $error("csr pready low");

endmodule

bind three_phase_spwm_min_max_injection tpspwm_checker #(
   .VOLT_WIDTH(VOLT_WIDTH),
   .TIME_WIDTH(TIME_WIDTH)
) u_tpspwm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_pready (csr_pready)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the three-phase sine PWM min-max injection block.
`timescale 1ns / 100ps

module tb;

   localparam int LATENCY = 16 + 3;
   localparam logic [tpspwm_pkg::CSR_ADDR_WIDTH-1:0] PERIOD_ADDR =
      {tpspwm_pkg::REG_SWITCHING_PERIOD, {tpspwm_pkg::CSR_INDEX_LSB{1'b0}}};

   typedef struct packed {
      logic        [15:0] vdc;
      logic signed [15:0] vc;
      logic signed [15:0] vb;
      logic signed [15:0] va;
   } phase_refs_type;

   typedef struct packed {
      logic        dc_fault;
      logic        clipped;
      logic [15:0] off_c;
      logic [15:0] off_b;
      logic [15:0] off_a;
   } off_times_type;

   typedef struct packed {
      phase_refs_type refs;
      logic           typed;
      off_times_type  want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [63:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] rsp_tdata;
   logic [tpspwm_pkg::RSP_USER_WIDTH-1:0] rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [tpspwm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [tpspwm_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [tpspwm_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   off_times_type  pending_off_times[$];
   stim_row_type   directed_rows[$];
   logic [15:0] period_ticks = 16'(tpspwm_pkg::PERIOD_RESET);
   int          sender_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          long_hold_req = 1'b0;
   int          error_count = 0;
   int          sent_count = 0;
   int          checked_count = 0;
   int          clip_count = 0;
   int          fault_count = 0;
   int          period_writes = 0;

   three_phase_spwm_min_max_injection u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),   // voltage_a, voltage_b, voltage_c, dc_link_voltage
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),   // off_time_a, off_time_b, off_time_c
      .rsp_tuser   (rsp_tuser),   // clipped, dc_fault
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("three_phase_spwm_min_max_injection test failed");
      $finish;
   end

   function automatic off_times_type predict_off_times(phase_refs_type refs,
                                                       logic [15:0] period);
      longint v [3];
      longint t [3];
      longint vmax, vmin, m, vdc;
      off_times_type res;
      res = '0;
      vdc = longint'(refs.vdc);
      v[0] = $signed(refs.va);
      v[1] = $signed(refs.vb);
      v[2] = $signed(refs.vc);
      if (vdc == 0) begin
         res.dc_fault = 1'b1;
         return res;
      end
      vmax = v[0];
      vmin = v[0];
      for (int i = 1; i < 3; i++) begin
         if (v[i] > vmax) vmax = v[i];
         if (v[i] < vmin) vmin = v[i];
      end
      for (int i = 0; i < 3; i++) begin
         m = 2 * v[i] - (vmax + vmin) + vdc;
         if (m < 0) begin
            t[i] = 0;
            res.clipped = 1'b1;
         end else if (m > 2 * vdc) begin
            t[i] = longint'(period);
            res.clipped = 1'b1;
         end else begin
            // round half up
            t[i] = (longint'(period) * m + vdc) / (2 * vdc);
         end
      end
      res.off_a = t[0][15:0];
      res.off_b = t[1][15:0];
      res.off_c = t[2][15:0];
      return res;
   endfunction

   function automatic phase_refs_type make_refs(int va, int vb, int vc, int vdc);
      phase_refs_type r;
      r.va = va[15:0];
      r.vb = vb[15:0];
      r.vc = vc[15:0];
      r.vdc = vdc[15:0];
      return r;
   endfunction

   function automatic off_times_type make_times(int a, int b, int c, bit clip, bit fault);
      off_times_type r;
      r.off_a = a[15:0];
      r.off_b = b[15:0];
      r.off_c = c[15:0];
      r.clipped = clip;
      r.dc_fault = fault;
      return r;
   endfunction

   function automatic phase_refs_type random_refs();
      phase_refs_type r;
      int kind;
      int amp;
      kind = $urandom_range(99);
      if (kind < 5) r.vdc = '0;
      else if (kind < 25) r.vdc = 16'($urandom_range(255, 1));
      else if (kind < 35) r.vdc = 16'hFFFF;
      else r.vdc = 16'($urandom_range(65535, 1));
      kind = $urandom_range(99);
      if (kind < 55) begin
         // balanced references, occasionally overdriven into saturation
         amp = r.vdc / 2 + $urandom_range(r.vdc / 8);
         if (amp > 32767) amp = 32767;
         r.va = 16'(int'($urandom_range(2 * amp)) - amp);
         r.vb = 16'(int'($urandom_range(2 * amp)) - amp);
         r.vc = 16'(int'($urandom_range(2 * amp)) - amp);
      end else if (kind < 90) begin
         r.va = 16'($urandom);
         r.vb = 16'($urandom);
         r.vc = 16'($urandom);
      end else begin
         r.va = 16'($urandom);
         r.vb = r.va;
         r.vc = r.va;
      end
      return r;
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_refs(input phase_refs_type refs, input bit typed,
                            input off_times_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= refs;
      do @(posedge clock); while (!req_tready);
      pending_off_times.push_back(typed ? want : predict_off_times(refs, period_ticks));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= PERIOD_ADDR;
      csr_pwdata <= {16'b0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      period_ticks = value;
      period_writes++;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_off_times.size() != 0) @(negedge clock);
   endtask

   // result side: random stalls plus one long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      off_times_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_off_times.size() == 0) begin
            $error("unexpected transaction on result channel: tdata %h tuser %b",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_off_times.pop_front();
            checked_count++;
            if (want.clipped) clip_count++;
            if (want.dc_fault) fault_count++;
            if (rsp_tdata[15:0] !== want.off_a) begin
               $error("off_time_a: expected %0d, actual %0d", want.off_a, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[31:16] !== want.off_b) begin
               $error("off_time_b: expected %0d, actual %0d", want.off_b, rsp_tdata[31:16]);
               error_count++;
            end
            if (rsp_tdata[47:32] !== want.off_c) begin
               $error("off_time_c: expected %0d, actual %0d", want.off_c, rsp_tdata[47:32]);
               error_count++;
            end
            if (rsp_tuser[tpspwm_pkg::USER_CLIPPED] !== want.clipped) begin
               $error("clipped: expected %0b, actual %0b", want.clipped,
                      rsp_tuser[tpspwm_pkg::USER_CLIPPED]);
               error_count++;
            end
            if (rsp_tuser[tpspwm_pkg::USER_DC_FAULT] !== want.dc_fault) begin
               $error("dc_fault: expected %0b, actual %0b", want.dc_fault,
                      rsp_tuser[tpspwm_pkg::USER_DC_FAULT]);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [15:0]  phase_period [8];
      int           phase_mode [8];
      stim_row_type row;
      int           items;

      // typed rows assume the reset period of 1000 ticks
      directed_rows.push_back({make_refs(0, 0, 0, 0), 1'b1, make_times(0, 0, 0, 0, 1)});
      directed_rows.push_back({make_refs(32767, -32768, 0, 0), 1'b1,
                               make_times(0, 0, 0, 0, 1)});
      directed_rows.push_back({make_refs(-32768, -32768, -32768, 0), 1'b1,
                               make_times(0, 0, 0, 0, 1)});
      directed_rows.push_back({make_refs(0, 0, 0, 1000), 1'b1,
                               make_times(500, 500, 500, 0, 0)});
      directed_rows.push_back({make_refs(0, 0, 0, 1), 1'b1, make_times(500, 500, 500, 0, 0)});
      directed_rows.push_back({make_refs(-32768, -32768, -32768, 1), 1'b1,
                               make_times(500, 500, 500, 0, 0)});
      // exactly zero and exactly full period: not a clip
      directed_rows.push_back({make_refs(100, -100, 0, 200), 1'b1,
                               make_times(1000, 0, 500, 0, 0)});
      directed_rows.push_back({make_refs(32767, -32768, 0, 1), 1'b1,
                               make_times(1000, 0, 1000, 1, 0)});
      directed_rows.push_back({make_refs(101, -100, 0, 200), 1'b0, off_times_type'('0)});
      directed_rows.push_back({make_refs(32767, 32767, 32767, 65535), 1'b0,
                               off_times_type'('0)});
      directed_rows.push_back({make_refs(32767, -32768, 0, 65535), 1'b0,
                               off_times_type'('0)});
      directed_rows.push_back({make_refs(21845, -21846, 0, 65535), 1'b0,
                               off_times_type'('0)});
      directed_rows.push_back({make_refs(-21846, 21845, -1, 43690), 1'b0,
                               off_times_type'('0)});
      directed_rows.push_back({make_refs(1, 0, 0, 2000), 1'b0, off_times_type'('0)});
      directed_rows.push_back({make_refs(3, -2, -1, 7), 1'b0, off_times_type'('0)});
      directed_rows.push_back({make_refs(1234, -5678, 4444, 65535), 1'b0,
                               off_times_type'('0)});

      phase_period = '{16'd1, 16'd65535, 16'($urandom_range(65535, 1)), 16'd2,
                       16'd1000, 16'($urandom_range(65535, 1)), 16'd65534, 16'd3};
      phase_mode = '{0, 1, 2, 3, 0, 1, 2, 3};

      reset = 1'b1;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_refs(row.refs, row.typed, row.want);
      end

      for (int p = 0; p < 8; p++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         write_period(phase_period[p]);
         sender_idle_pct = (phase_mode[p] == 1) ? 67 : (phase_mode[p] == 3) ? 14 : 0;
         recv_stall_pct  = (phase_mode[p] == 2) ? 67 : (phase_mode[p] == 3) ? 14 : 0;
         if (p == 0) long_hold_req = 1'b1;
         items = 85;
         for (int n = 0; n < items; n++) begin
            if (p == 5 && n == items / 2) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
            send_refs(random_refs(), 1'b0, off_times_type'('0));
         end
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (LATENCY + 20) @(posedge clock);

      $display("%0d transactions sent, %0d results checked (%0d clipped, %0d dc faults)",
               sent_count, checked_count, clip_count, fault_count);
      $display("%0d period writes, extremes 1 and 65535, four idle and stall mixes",
               period_writes);
      if (error_count == 0 && pending_off_times.size() == 0) begin
         $display("three_phase_spwm_min_max_injection test passed");
      end else begin
         $display("three_phase_spwm_min_max_injection test failed");
      end
      $finish;
   end

endmodule
